FILE: hdl/mps_pkg.sv
// Shared types, constants and the hue colour function of the metaball pixel shader.
package mps_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_BLOBS     = 2'd1;
	localparam logic [1:0] CFG_HUE       = 2'd2;

	localparam logic [47:0] THRESHOLD_RST = 48'd1288490;
	localparam logic [4:0]  BLOBS_RST     = 5'd10;
	localparam logic [15:0] HUE_RST       = 16'd0;

	localparam logic [47:0] Q48_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [16:0] ONE_Q16    = 17'h10000;
	localparam logic [17:0] THREE_Q16  = 18'd196608;
	localparam logic [15:0] QUARTER    = 16'h4000;
	localparam logic [17:0] D_SAT      = 18'd16;
	localparam logic [6:0]  SQRT_STEPS = 7'd17;
	localparam logic [6:0]  DIV_STEPS  = 7'd65;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic load;
		logic start;
		logic diff;
		logic sq;
		logic rinit;
		logic rstep;
		logic dsum;
		logic dsq;
		logic div1_init;
		logic div2_init;
		logic divt_init;
		logic dstep;
		logic acc;
		logic cmp;
		logic tchk;
		logic sm1;
		logic sm2;
		logic mix;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last_blob;
		logic d_small;
		logic lit;
		logic t_full;
	} sts_t;

	function automatic rgb_t hue_rgb(input logic [15:0] h);
		logic [18:0] h6;
		logic [15:0] f;
		logic [23:0] upp;
		logic [24:0] dnp;
		logic [7:0]  up;
		logic [7:0]  dn;
		rgb_t        c;
		h6  = 19'(h) * 19'd6;
		f   = h6[15:0];
		upp = 24'(f) * 24'd255;
		dnp = 25'(ONE_Q16 - 17'(f)) * 25'd255;
		up  = upp[23:16];
		dn  = dnp[23:16];
		case (h6[18:16])
			3'd0: c = '{8'd255, up, 8'd0};
			3'd1: c = '{dn, 8'd255, 8'd0};
			3'd2: c = '{8'd0, 8'd255, up};
			3'd3: c = '{8'd0, dn, 8'd255};
			3'd4: c = '{up, 8'd0, 8'd255};
			default: c = '{8'd255, 8'd0, dn};
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/mps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/mps_ctrl.sv
// Sequencer of the metaball pixel shader: item handshake, step counter, command issue.
module mps_ctrl import mps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic opcode,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [20:0] {
		S_IDLE = 21'h000001,
		S_RD   = 21'h000002,
		S_DIFF = 21'h000004,
		S_SQ   = 21'h000008,
		S_RINI = 21'h000010,
		S_ROOT = 21'h000020,
		S_DSUM = 21'h000040,
		S_DSQ  = 21'h000080,
		S_D1I  = 21'h000100,
		S_D1   = 21'h000200,
		S_D2I  = 21'h000400,
		S_D2   = 21'h000800,
		S_ACC  = 21'h001000,
		S_CMP  = 21'h002000,
		S_TCHK = 21'h004000,
		S_TI   = 21'h008000,
		S_TD   = 21'h010000,
		S_SM1  = 21'h020000,
		S_SM2  = 21'h040000,
		S_MIX  = 21'h080000,
		S_EMIT = 21'h100000
	} state_t;

	state_t     state_q, state_d;
	logic [6:0] cnt_q;
	logic       out_vld_q;
	logic       accept, free, cnt_clr, cnt_inc, root_end, div_end;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && (state_q == S_IDLE);
	assign free         = !out_vld_q || !result_stall;
	assign result_valid = out_vld_q;
	assign root_end     = (cnt_q == SQRT_STEPS - 7'd1);
	assign div_end      = (cnt_q == DIV_STEPS - 7'd1);

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cnt_clr       = 1'b0;
		cnt_inc       = 1'b0;
		cmd.load      = accept && (opcode == OP_LOAD);
		cmd.start     = accept && (opcode == OP_SHADE);
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_d = sts.n_zero ? S_CMP : S_RD;
				end
			end
			S_RD: state_d = S_DIFF;
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_RINI;
			end
			S_RINI: begin
				cmd.rinit = 1'b1;
				cnt_clr   = 1'b1;
				state_d   = S_ROOT;
			end
			S_ROOT: begin
				cmd.rstep = 1'b1;
				cnt_inc   = 1'b1;
				if (root_end) state_d = S_DSUM;
			end
			S_DSUM: begin
				cmd.dsum = 1'b1;
				state_d  = S_DSQ;
			end
			S_DSQ: begin
				cmd.dsq = 1'b1;
				state_d = sts.d_small ? S_ACC : S_D1I;
			end
			S_D1I: begin
				cmd.div1_init = 1'b1;
				cnt_clr       = 1'b1;
				state_d       = S_D1;
			end
			S_D1: begin
				cmd.dstep = 1'b1;
				cnt_inc   = 1'b1;
				if (div_end) state_d = S_D2I;
			end
			S_D2I: begin
				cmd.div2_init = 1'b1;
				cnt_clr       = 1'b1;
				state_d       = S_D2;
			end
			S_D2: begin
				cmd.dstep = 1'b1;
				cnt_inc   = 1'b1;
				if (div_end) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_blob ? S_CMP : S_RD;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sts.lit ? S_TCHK : S_EMIT;
			end
			S_TCHK: begin
				cmd.tchk = 1'b1;
				state_d  = sts.t_full ? S_SM1 : S_TI;
			end
			S_TI: begin
				cmd.divt_init = 1'b1;
				cnt_clr       = 1'b1;
				state_d       = S_TD;
			end
			S_TD: begin
				cmd.dstep = 1'b1;
				cnt_inc   = 1'b1;
				if (div_end) state_d = S_SM1;
			end
			S_SM1: begin
				cmd.sm1 = 1'b1;
				state_d = S_SM2;
			end
			S_SM2: begin
				cmd.sm2 = 1'b1;
				state_d = S_MIX;
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 7'd1;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_root_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> (cnt_q < SQRT_STEPS))
		else $error("square root ran past its step count");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D1 || state_q == S_D2 || state_q == S_TD) |-> (cnt_q < DIV_STEPS))
		else $error("divider ran past its step count");
	a_shade_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_SHADE) |=> (state_q != S_IDLE))
		else $error("shade item did not start work");
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");
`endif
endmodule

FILE: hdl/mps_dp.sv
// Datapath of the metaball pixel shader: blob store, field sum, threshold, colour mix.
module mps_dp import mps_pkg::*; #(
	parameter int MAX_BLOBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic [3:0]  blob_slot,
	input  logic [15:0] blob_center_x,
	input  logic [15:0] blob_center_y,
	input  logic [15:0] blob_size,
	input  logic [5:0]  pixel_col,
	input  logic [5:0]  pixel_row,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        lit,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	localparam int AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;

	logic [47:0] th_q;
	logic [4:0]  nuse_q;
	logic [15:0] hue_q;

	logic [5:0]  col_q, row_q;
	logic [6:0]  idx_q;
	logic [47:0] sum_q;
	logic [15:0] ax_q, ay_q, size_q;
	logic [31:0] axx_q, ayy_q;
	logic [33:0] v_q;
	logic [17:0] rem_q;
	logic [16:0] root_q;
	logic [17:0] d_q;
	logic [35:0] d2_q;
	logic [64:0] dq_q;
	logic [47:0] drem_q, den_q, diff_q;
	logic        lit_q, tfull_q;
	logic [16:0] t_q, s_q;
	logic [33:0] tt_q;
	rgb_t        c1_q, c2_q;
	logic [7:0]  mr_q, mg_q, mb_q;

	logic [47:0] rdata;
	logic        ram_we;
	logic [6:0]  slot_ext, n_eff;
	logic [16:0] px, py, dx, dy;
	logic [19:0] r_remv, r_trial;
	logic        r_ge;
	logic [48:0] d_remv, d_den;
	logic        d_ge;
	logic [47:0] term;
	logic [48:0] sum_n;
	logic [16:0] t_n, s_inv;
	logic [17:0] w;
	logic [51:0] sp;
	logic [25:0] m_r, m_g, m_b;

	assign slot_ext = 7'(blob_slot);
	assign ram_we   = cmd.load && (slot_ext < 7'(MAX_BLOBS));
	assign n_eff    = (7'(nuse_q) > 7'(MAX_BLOBS)) ? 7'(MAX_BLOBS) : 7'(nuse_q);

	mps_ram #(.WIDTH(48), .DEPTH(MAX_BLOBS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata ({blob_center_x, blob_center_y, blob_size}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign px = {3'b000, col_q, 8'h00};
	assign py = {3'b000, row_q, 8'h00};
	assign dx = px - {rdata[47], rdata[47:32]};
	assign dy = py - {rdata[31], rdata[31:16]};

	assign r_remv  = {rem_q, v_q[33:32]};
	assign r_trial = {1'b0, root_q, 2'b01};
	assign r_ge    = (r_remv >= r_trial);

	assign d_remv = {drem_q, dq_q[64]};
	assign d_den  = {1'b0, den_q};
	assign d_ge   = (d_remv >= d_den);

	assign term  = sts.d_small ? Q48_MAX : dq_q[47:0];
	assign sum_n = {1'b0, sum_q} + {1'b0, term};

	assign t_n   = tfull_q ? ONE_Q16 : dq_q[16:0];
	assign w     = THREE_Q16 - {t_q, 1'b0};
	assign sp    = 52'(tt_q) * 52'(w);
	assign s_inv = ONE_Q16 - s_q;
	assign m_r   = 26'(c1_q.r) * 26'(s_q) + 26'(c2_q.r) * 26'(s_inv);
	assign m_g   = 26'(c1_q.g) * 26'(s_q) + 26'(c2_q.g) * 26'(s_inv);
	assign m_b   = 26'(c1_q.b) * 26'(s_q) + 26'(c2_q.b) * 26'(s_inv);

	assign sts.n_zero    = (n_eff == 7'd0);
	assign sts.last_blob = ((idx_q + 7'd1) >= n_eff);
	assign sts.d_small   = (d_q <= D_SAT);
	assign sts.lit       = (sum_q > th_q);
	assign sts.t_full    = (diff_q >= th_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_q   <= THRESHOLD_RST;
			nuse_q <= BLOBS_RST;
			hue_q  <= HUE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_THRESHOLD: th_q   <= cfg_data;
				CFG_BLOBS:     nuse_q <= cfg_data[4:0];
				CFG_HUE:       hue_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
			sum_q <= '0;
			idx_q <= '0;
		end
		if (cmd.diff) begin
			ax_q   <= dx[16] ? 16'(~dx + 17'd1) : dx[15:0];
			ay_q   <= dy[16] ? 16'(~dy + 17'd1) : dy[15:0];
			size_q <= rdata[15:0];
		end
		if (cmd.sq) begin
			axx_q <= 32'(ax_q) * 32'(ax_q);
			ayy_q <= 32'(ay_q) * 32'(ay_q);
		end
		if (cmd.rinit) begin
			v_q    <= 34'(axx_q) + 34'(ayy_q);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.rstep) begin
			rem_q  <= r_ge ? 18'(r_remv - r_trial) : r_remv[17:0];
			root_q <= {root_q[15:0], r_ge};
			v_q    <= {v_q[31:0], 2'b00};
		end
		if (cmd.dsum) begin
			d_q <= 18'(root_q) + 18'(size_q[15:1]);
		end
		if (cmd.dsq) begin
			d2_q <= 36'(d_q) * 36'(d_q);
		end
		if (cmd.div1_init) begin
			dq_q   <= {1'b1, 64'd0};
			drem_q <= '0;
			den_q  <= 48'(d2_q);
		end
		if (cmd.div2_init) begin
			drem_q <= '0;
		end
		if (cmd.divt_init) begin
			dq_q   <= {1'b0, diff_q, 16'h0000};
			drem_q <= '0;
			den_q  <= th_q;
		end
		if (cmd.dstep) begin
			drem_q <= d_ge ? 48'(d_remv - d_den) : d_remv[47:0];
			dq_q   <= {dq_q[63:0], d_ge};
		end
		if (cmd.acc) begin
			sum_q <= sum_n[48] ? Q48_MAX : sum_n[47:0];
			idx_q <= idx_q + 7'd1;
		end
		if (cmd.cmp) begin
			lit_q  <= sts.lit;
			diff_q <= sum_q - th_q;
		end
		if (cmd.tchk) begin
			tfull_q <= sts.t_full;
		end
		if (cmd.sm1) begin
			t_q  <= t_n;
			tt_q <= 34'(t_n) * 34'(t_n);
			c1_q <= hue_rgb(hue_q);
			c2_q <= hue_rgb(hue_q + QUARTER);
		end
		if (cmd.sm2) begin
			s_q <= sp[48:32];
		end
		if (cmd.mix) begin
			mr_q <= m_r[23:16];
			mg_q <= m_g[23:16];
			mb_q <= m_b[23:16];
		end
		if (cmd.emit) begin
			lit   <= lit_q;
			red   <= lit_q ? mr_q : 8'd0;
			green <= lit_q ? mg_q : 8'd0;
			blue  <= lit_q ? mb_q : 8'd0;
		end
	end
endmodule

FILE: hdl/metaball_pixel_shader.sv
// Top level of the metaball pixel shader: sequencer and datapath.
//
//  channel  | handshake                   | payload
//  item     | item_valid / item_stall     | opcode, blob_slot, blob_center_x/y, blob_size,
//           |                             | pixel_col, pixel_row
//  result   | result_valid / result_stall | lit, red, green, blue
//  config   | cfg_wr_en                   | cfg_index, cfg_data
//
// A load item writes its blob to the store and gives no result.
// A shade item runs each blob in turn; a blob whose distance needs them takes the two
// 65-step divisions of the shared restoring divider, which a saturated blob skips, then
// threshold compare; for a lit pixel threshold division where needed, smoothstep and mix; then emit.
// Reset clears the sequencer and loads the register defaults; the blob store is not cleared.
// A stalled result holds; a finished item waits in emit until the result register frees.
module metaball_pixel_shader import mps_pkg::*; #(
	parameter int MAX_BLOBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        opcode,
	input  logic [3:0]  blob_slot,
	input  logic [15:0] blob_center_x,
	input  logic [15:0] blob_center_y,
	input  logic [15:0] blob_size,
	input  logic [5:0]  pixel_col,
	input  logic [5:0]  pixel_row,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        lit,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	cmd_t cmd;
	sts_t sts;

	mps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	mps_dp #(.MAX_BLOBS(MAX_BLOBS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.blob_slot     (blob_slot),
		.blob_center_x (blob_center_x),
		.blob_center_y (blob_center_y),
		.blob_size     (blob_size),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.cmd           (cmd),
		.sts           (sts),
		.lit           (lit),
		.red           (red),
		.green         (green),
		.blue          (blue)
	);
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the metaball pixel shader, with blob loads and pixel shading.
`timescale 1ns / 1ps

module tb;
	import mps_pkg::*;

	typedef struct {
		logic       lit;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	class shade_scoreboard;
		pixel_t      pixel_q[$];
		logic [15:0] bx[16];
		logic [15:0] by[16];
		logic [15:0] bs[16];
		logic [47:0] thr;
		logic [4:0]  nblob;
		logic [15:0] hue;

		function new();
			thr   = THRESHOLD_RST;
			nblob = BLOBS_RST;
			hue   = HUE_RST;
			foreach (bx[i]) begin
				bx[i] = '0;
				by[i] = '0;
				bs[i] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [47:0] v);
			case (idx)
				CFG_THRESHOLD: thr = v;
				CFG_BLOBS: nblob = v[4:0];
				CFG_HUE: hue = v[15:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] trial;
			res = 0;
			for (int k = 31; k >= 0; k--) begin
				trial = res | (64'd1 << k);
				if (trial * trial <= v)
					res = trial;
			end
			return res;
		endfunction

		function logic [47:0] blob_field(logic [5:0] col, logic [5:0] row, int slot);
			longint dx, dy;
			logic [63:0] d;
			logic [127:0] d4;
			dx = longint'({col, 8'h00}) - longint'($signed(bx[slot]));
			dy = longint'({row, 8'h00}) - longint'($signed(by[slot]));
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			d = int_sqrt(64'(dx * dx + dy * dy)) + 64'(bs[slot] >> 1);
			if (d <= 16)
				return Q48_MAX;
			d4 = 128'(d) * d * d * d;
			return 48'((128'd1 << 64) / d4);
		endfunction

		function void hue_colour_of(logic [15:0] h, output logic [7:0] r, output logic [7:0] g,
				output logic [7:0] b);
			logic [31:0] h6, f, up, dn;
			h6 = 32'(h) * 6;
			f  = h6 & 32'hFFFF;
			up = (255 * f) >> 16;
			dn = (255 * (32'h10000 - f)) >> 16;
			case (h6 >> 16)
				0: begin r = 255; g = up[7:0]; b = 0; end
				1: begin r = dn[7:0]; g = 255; b = 0; end
				2: begin r = 0; g = 255; b = up[7:0]; end
				3: begin r = 0; g = dn[7:0]; b = 255; end
				4: begin r = up[7:0]; g = 0; b = 255; end
				default: begin r = 255; g = 0; b = dn[7:0]; end
			endcase
		endfunction

		function logic [7:0] blend(logic [7:0] c1, logic [7:0] c2, logic [31:0] s);
			logic [63:0] acc;
			acc = 64'(c1) * s + 64'(c2) * (64'h10000 - s);
			return acc[23:16];
		endfunction

		function void note_item(logic op, logic [3:0] slot, logic [15:0] cx, logic [15:0] cy,
				logic [15:0] sz, logic [5:0] col, logic [5:0] row);
			logic [48:0] sum;
			logic [63:0] tq, s;
			logic [31:0] t;
			logic [7:0]  r1, g1, b1, r2, g2, b2;
			int          n;
			pixel_t      px;
			if (op == OP_LOAD) begin
				bx[slot] = cx;
				by[slot] = cy;
				bs[slot] = sz;
				return;
			end
			n = (nblob > 16) ? 16 : nblob;
			sum = 0;
			for (int i = 0; i < n; i++) begin
				sum = sum + blob_field(col, row, i);
				if (sum > Q48_MAX)
					sum = Q48_MAX;
			end
			if (sum <= thr) begin
				px = '{1'b0, 8'd0, 8'd0, 8'd0};
			end else begin
				if (thr == 0) begin
					t = 32'h10000;
				end else begin
					tq = (64'(sum - thr) << 16) / thr;
					t  = (tq > 64'h10000) ? 32'h10000 : tq[31:0];
				end
				s = (64'(t) * t * (64'd196608 - 2 * t)) >> 32;
				hue_colour_of(hue, r1, g1, b1);
				hue_colour_of(hue + 16'h4000, r2, g2, b2);
				px = '{1'b1, blend(r1, r2, s[31:0]), blend(g1, g2, s[31:0]),
					blend(b1, b2, s[31:0])};
			end
			pixel_q.insert(pixel_q.size(), px);
		endfunction

		function bit check(logic l, logic [7:0] r, logic [7:0] g, logic [7:0] b,
				output string msg);
			pixel_t e;
			if (pixel_q.size() == 0) begin
				msg = $sformatf("unexpected result lit=%0d rgb=%0d,%0d,%0d", l, r, g, b);
				return 0;
			end
			e = pixel_q.pop_front();
			if (l !== e.lit || r !== e.r || g !== e.g || b !== e.b) begin
				msg = $sformatf("pixel mismatch: got lit=%0d rgb=%0d,%0d,%0d exp lit=%0d rgb=%0d,%0d,%0d",
					l, r, g, b, e.lit, e.r, e.g, e.b);
				return 0;
			end
			msg = "";
			return 1;
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction
	endclass

	localparam int STALL_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	logic        opcode;
	logic [3:0]  blob_slot;
	logic [15:0] blob_center_x;
	logic [15:0] blob_center_y;
	logic [15:0] blob_size;
	logic [5:0]  pixel_col;
	logic [5:0]  pixel_row;
	logic        result_valid;
	logic        result_stall;
	logic        lit;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	shade_scoreboard sb;
	int  errors;
	int  idle_cnt;
	int  sent;
	bit  gaps_on;

	metaball_pixel_shader u_top (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report(string msg);
		$display("tb: %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		bit    hit;
		hit = 0;
		if (arst_n && item_valid && !item_stall) begin
			sb.note_item(opcode, blob_slot, blob_center_x, blob_center_y, blob_size,
				pixel_col, pixel_row);
			hit = 1;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (!sb.check(lit, red, green, blue, msg))
				report(msg);
			hit = 1;
		end
		if (hit || !arst_n) begin
			idle_cnt = 0;
		end else begin
			idle_cnt++;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	always @(negedge clk)
		result_stall <= gaps_on && ($urandom_range(99) < 37);

	task automatic send(logic op, logic [3:0] slot, logic [15:0] cx, logic [15:0] cy,
			logic [15:0] sz, logic [5:0] col, logic [5:0] row);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 37) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid    <= 1'b1;
		opcode        <= op;
		blob_slot     <= slot;
		blob_center_x <= cx;
		blob_center_y <= cy;
		blob_size     <= sz;
		pixel_col     <= col;
		pixel_row     <= row;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic rand_load();
		logic [15:0] cx, cy, sz;
		if ($urandom_range(9) < 8) begin
			cx = 16'($urandom_range(16383));
			cy = 16'($urandom_range(16383));
		end else begin
			cx = 16'($urandom);
			cy = 16'($urandom);
		end
		sz = ($urandom_range(9) < 8) ? 16'($urandom_range(1023)) : 16'($urandom);
		send(OP_LOAD, 4'($urandom_range(15)), cx, cy, sz, 6'($urandom), 6'($urandom));
	endtask

	task automatic rand_shade();
		send(OP_SHADE, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			6'($urandom_range(63)), 6'($urandom_range(63)));
	endtask

	initial begin
		logic [47:0] th;
		logic [4:0]  nb;
		int          per;
		sb = new();
		errors = 0;
		idle_cnt = 0;
		sent = 0;
		gaps_on = 1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		opcode = OP_LOAD;
		blob_slot = '0;
		blob_center_x = '0;
		blob_center_y = '0;
		blob_size = '0;
		pixel_col = '0;
		pixel_row = '0;
		result_stall = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// every slot written before any shade reads it
		send(OP_LOAD, 4'd0, 16'h0000, 16'h0000, 16'h0000, 6'd0, 6'd0);
		send(OP_LOAD, 4'd1, 16'h8000, 16'h8000, 16'hFFFF, 6'd63, 6'd63);
		send(OP_LOAD, 4'd2, 16'h7FFF, 16'h7FFF, 16'h0000, 6'd0, 6'd0);
		send(OP_LOAD, 4'd3, 16'h3F00, 16'h3F00, 16'h0020, 6'd0, 6'd0);
		for (int i = 4; i < 16; i++)
			send(OP_LOAD, 4'(i), 16'(i * 1024), 16'(16383 - i * 1000), 16'(i * 40), 6'd0, 6'd0);
		send(OP_SHADE, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0);
		send(OP_SHADE, 4'd0, 16'h0, 16'h0, 16'h0, 6'd63, 6'd63);
		send(OP_SHADE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd20, 6'd40);
		send(OP_SHADE, 4'd0, 16'h0, 16'h0, 16'h0, 6'd5, 6'd58);
		drain();
		// saturated sum over every slot, then more blobs than the store holds
		write_reg(CFG_BLOBS, 5'd16);
		write_reg(CFG_THRESHOLD, Q48_MAX);
		send(OP_SHADE, 4'd0, 16'h0, 16'h0, 16'h0, 6'd0, 6'd0);
		drain();
		write_reg(CFG_BLOBS, 5'd31);
		write_reg(CFG_THRESHOLD, 48'd0);
		write_reg(CFG_HUE, 16'hFFFF);
		send(OP_SHADE, 4'd0, 16'h0, 16'h0, 16'h0, 6'd63, 6'd0);
		drain();

		while (sent < 1400) begin
			case ($urandom_range(5))
				0: th = 48'd1;
				1: th = 48'd0;
				2: th = Q48_MAX;
				3: th = THRESHOLD_RST;
				4: th = 48'($urandom_range(1 << 24));
				default: th = {16'($urandom), 32'($urandom)};
			endcase
			case ($urandom_range(11))
				0: nb = 5'd16;
				1: nb = 5'($urandom_range(17, 31));
				2: nb = 5'd0;
				default: nb = 5'($urandom_range(1, 4));
			endcase
			write_reg(CFG_THRESHOLD, th);
			write_reg(CFG_BLOBS, nb);
			write_reg(CFG_HUE, ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 16384)
				: 16'($urandom));
			per = (nb >= 8) ? 12 : 90;
			gaps_on = !(sent > 600 && sent < 850);
			for (int k = 0; k < per; k++) begin
				if ($urandom_range(99) < 35)
					rand_load();
				else
					rand_shade();
			end
			drain();
		end

		gaps_on = 0;
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: metaball_pixel_shader.f
hdl/mps_pkg.sv
hdl/mps_ram.sv
hdl/mps_ctrl.sv
hdl/mps_dp.sv
hdl/metaball_pixel_shader.sv
tb/sv/tb.sv
